[rtl/abp_pkg.sv]
// ----------------------------------------------------------------------------
// abp_pkg
// Shared widths, register indexes and beat types of the alpha-over blend unit.
// ----------------------------------------------------------------------------
package abp_pkg;

    localparam int unsigned POS_W       = 14;
    localparam int unsigned CH_W        = 8;
    localparam int unsigned PROD_W      = 16;
    localparam int unsigned ASUM_W      = 16;
    localparam int unsigned NUM_W       = 24;
    localparam int unsigned IDX_W       = 24;
    localparam int unsigned CFG_DATA_W  = 13;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned NUM_CH      = 3;
    localparam int unsigned DIV_STEPS   = 8;
    localparam int unsigned RECIP_W     = 32;
    localparam int unsigned RESET_DIM   = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

    localparam logic [CH_W-1:0]   CH_MAX       = 8'd255;
    localparam logic [ASUM_W-1:0] ASUM_BLOCK   = 16'hFFFF;
    localparam logic [ASUM_W-1:0] RECIP_255    = 16'h8081;
    localparam int unsigned       RECIP_SHIFT  = 23;

    typedef logic [NUM_CH-1:0][NUM_W-1:0] num_vec_t;
    typedef logic [NUM_CH-1:0][CH_W-1:0]  chan_vec_t;
    typedef logic [NUM_CH-1:0][PROD_W-1:0] prod_vec_t;

    typedef struct packed {
        logic              write_enable;
        logic [IDX_W-1:0]  pixel_index;
        logic [CH_W-1:0]   alpha;
        logic [ASUM_W-1:0] alpha_sum;
        num_vec_t          rem;
        chan_vec_t         quo;
    } div_beat_t;

endpackage

[rtl/abp_ifs.sv]
// ----------------------------------------------------------------------------
// abp interfaces
// Pixel input, pixel output and configuration write channels.
// ----------------------------------------------------------------------------
interface abp_pix_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [abp_pkg::POS_W-1:0] pos_x;
    logic signed [abp_pkg::POS_W-1:0] pos_y;
    logic [abp_pkg::CH_W-1:0]         src_red;
    logic [abp_pkg::CH_W-1:0]         src_green;
    logic [abp_pkg::CH_W-1:0]         src_blue;
    logic [abp_pkg::CH_W-1:0]         src_alpha;
    logic [abp_pkg::CH_W-1:0]         dst_red;
    logic [abp_pkg::CH_W-1:0]         dst_green;
    logic [abp_pkg::CH_W-1:0]         dst_blue;
    logic [abp_pkg::CH_W-1:0]         dst_alpha;

    modport source (output valid, pos_x, pos_y, src_red, src_green, src_blue, src_alpha,
                    dst_red, dst_green, dst_blue, dst_alpha, input ready);
    modport sink   (input valid, pos_x, pos_y, src_red, src_green, src_blue, src_alpha,
                    dst_red, dst_green, dst_blue, dst_alpha, output ready);
endinterface

interface abp_pix_out_if;
    logic                      valid;
    logic                      ready;
    logic                      write_enable;
    logic [abp_pkg::IDX_W-1:0] pixel_index;
    logic [abp_pkg::CH_W-1:0]  out_red;
    logic [abp_pkg::CH_W-1:0]  out_green;
    logic [abp_pkg::CH_W-1:0]  out_blue;
    logic [abp_pkg::CH_W-1:0]  out_alpha;

    modport source (output valid, write_enable, pixel_index, out_red, out_green, out_blue,
                    out_alpha, input ready);
    modport sink   (input valid, write_enable, pixel_index, out_red, out_green, out_blue,
                    out_alpha, output ready);
endinterface

interface abp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [abp_pkg::CFG_IDX_W-1:0]  index;
    logic [abp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/alpha_over_pixel_blend_unit.sv]
// ----------------------------------------------------------------------------
// alpha_over_pixel_blend_unit
// Porter-Duff over blend of one RGBA8 pixel with frame clipping and indexing.
// Pipeline: 3 front stages, then 8 divider stages, one quotient bit per stage.
// Throughput: one pixel per cycle while the output is not stalled; each stage
// holds its beat only while the next one is full and stalled, so bubbles are
// squeezed out under backpressure.
// Reset: pipeline empties, frame width and height return to min(1024, MAX_DIM).
// ----------------------------------------------------------------------------
module alpha_over_pixel_blend_unit #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    abp_pix_in_if.sink   pix_in,
    abp_pix_out_if.source pix_out,
    abp_cfg_if.sink      cfg
);

    localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
    localparam int unsigned CMP_W = abp_pkg::CFG_DATA_W + 2;
    localparam int unsigned RESET_CLAMP = (abp_pkg::RESET_DIM > MAX_DIM) ?
                                          MAX_DIM : abp_pkg::RESET_DIM;

    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;
    logic [DIM_W-1:0]   cfg_dim_next;
    logic               cfg_write;

    logic               pipe_valid [abp_pkg::DIV_STEPS+1];
    logic               pipe_ready [abp_pkg::DIV_STEPS+1];
    abp_pkg::div_beat_t pipe_beat  [abp_pkg::DIV_STEPS+1];
    abp_pkg::div_beat_t last_beat;

    // clamp to the largest supported frame on write
    assign cfg.ready    = 1'b1;
    assign cfg_write    = cfg.valid && cfg.ready;
    assign cfg_dim_next = (CMP_W'(cfg.data) > CMP_W'(MAX_DIM)) ?
                          DIM_W'(MAX_DIM) : DIM_W'(cfg.data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_W'(RESET_CLAMP);
            frame_height_reg <= DIM_W'(RESET_CLAMP);
        end
        else if (cfg_write)
        begin
            unique case (cfg.index)
                abp_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_dim_next;
                abp_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_dim_next;
                default:                   ;
            endcase
        end
    end

    abp_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_in       (pix_in),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .out_valid    (pipe_valid[0]),
        .out_ready    (pipe_ready[0]),
        .out_beat     (pipe_beat[0])
    );

    for (genvar g = 0; g < abp_pkg::DIV_STEPS; g++)
    begin : g_div
        abp_div_step #(
            .STEP (abp_pkg::DIV_STEPS - 1 - g)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[g]),
            .in_ready  (pipe_ready[g]),
            .in_beat   (pipe_beat[g]),
            .out_valid (pipe_valid[g+1]),
            .out_ready (pipe_ready[g+1]),
            .out_beat  (pipe_beat[g+1])
        );
    end

    assign last_beat                          = pipe_beat[abp_pkg::DIV_STEPS];
    assign pipe_ready[abp_pkg::DIV_STEPS]     = pix_out.ready;
    assign pix_out.valid                      = pipe_valid[abp_pkg::DIV_STEPS];
    assign pix_out.write_enable               = last_beat.write_enable;
    assign pix_out.pixel_index                = last_beat.pixel_index;
    assign pix_out.out_red                    = last_beat.quo[0];
    assign pix_out.out_green                  = last_beat.quo[1];
    assign pix_out.out_blue                   = last_beat.quo[2];
    assign pix_out.out_alpha                  = last_beat.alpha;

    assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid && !pix_out.write_enable |->
            pix_out.pixel_index == '0 && pix_out.out_red == '0 &&
            pix_out.out_green == '0 && pix_out.out_blue == '0 && pix_out.out_alpha == '0)
        else $error("blocked pixel carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        !pix_in.ready |-> pix_out.valid && !pix_out.ready)
        else $error("input stalled without output backpressure");

    assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(frame_width_reg) <= CMP_W'(MAX_DIM) &&
        CMP_W'(frame_height_reg) <= CMP_W'(MAX_DIM))
        else $error("frame size above supported maximum");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && cfg.index == abp_pkg::REG_FRAME_WIDTH |=>
            frame_width_reg == $past(cfg_dim_next))
        else $error("frame width write lost");

endmodule

[rtl/abp_front.sv]
// ----------------------------------------------------------------------------
// abp_front
// Three-stage front end: clipping, channel products, weighted sums, combined
// alpha, pixel index and result alpha; hands a beat to the divider chain.
// ----------------------------------------------------------------------------
module abp_front #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    abp_pix_in_if.sink                            pix_in,
    input  logic [$clog2(MAX_DIM+1)-1:0]          frame_width,
    input  logic [$clog2(MAX_DIM+1)-1:0]          frame_height,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output abp_pkg::div_beat_t                    out_beat
);

    localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
    localparam int unsigned CRD_W = $clog2(MAX_DIM);
    localparam int unsigned CMP_W = abp_pkg::POS_W + 1;
    localparam int unsigned EXT_W = (CRD_W + DIM_W + 1 > abp_pkg::IDX_W) ?
                                    (CRD_W + DIM_W + 1) : abp_pkg::IDX_W;

    // stage 1
    logic                          s1_valid_reg;
    logic                          s1_in_frame_reg;
    logic [abp_pkg::CH_W-1:0]      s1_sa_reg;
    logic [abp_pkg::ASUM_W-1:0]    s1_sa255_reg;
    logic [abp_pkg::ASUM_W-1:0]    s1_dap_reg;
    abp_pkg::prod_vec_t            s1_sp_reg;
    abp_pkg::prod_vec_t            s1_dp_reg;
    logic [abp_pkg::IDX_W-1:0]     s1_idx_reg;
    logic                          s1_in_frame_next;
    logic [abp_pkg::ASUM_W-1:0]    s1_sa255_next;
    logic [abp_pkg::ASUM_W-1:0]    s1_dap_next;
    abp_pkg::prod_vec_t            s1_sp_next;
    abp_pkg::prod_vec_t            s1_dp_next;
    logic [EXT_W-1:0]              s1_idx_full;
    logic [abp_pkg::CH_W-1:0]      inv_sa_in;
    logic [CMP_W-1:0]              x_ext;
    logic [CMP_W-1:0]              y_ext;
    abp_pkg::chan_vec_t            src_vec;
    abp_pkg::chan_vec_t            dst_vec;

    // stage 2
    logic                          s2_valid_reg;
    logic                          s2_we_reg;
    logic [abp_pkg::ASUM_W-1:0]    s2_asum_reg;
    abp_pkg::num_vec_t             s2_num_reg;
    logic [abp_pkg::IDX_W-1:0]     s2_idx_reg;
    logic                          s2_we_next;
    logic [abp_pkg::ASUM_W-1:0]    s2_asum_next;
    abp_pkg::num_vec_t             s2_num_next;
    logic [abp_pkg::CH_W-1:0]      s1_inv_sa;

    // stage 3
    logic                          s3_valid_reg;
    abp_pkg::div_beat_t            s3_beat_reg;
    abp_pkg::div_beat_t            s3_beat_next;
    logic [abp_pkg::RECIP_W-1:0]   alpha_prod;

    logic                          s1_ready;
    logic                          s2_ready;
    logic                          s3_ready;

    assign s3_ready     = !s3_valid_reg || out_ready;
    assign s2_ready     = !s2_valid_reg || s3_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign pix_in.ready = s1_ready;

    assign src_vec = {pix_in.src_blue, pix_in.src_green, pix_in.src_red};
    assign dst_vec = {pix_in.dst_blue, pix_in.dst_green, pix_in.dst_red};

    always_comb
    begin
        x_ext = {1'b0, pix_in.pos_x};
        y_ext = {1'b0, pix_in.pos_y};
        s1_in_frame_next = !pix_in.pos_x[abp_pkg::POS_W-1] &&
                           !pix_in.pos_y[abp_pkg::POS_W-1] &&
                           (x_ext < CMP_W'(frame_width)) &&
                           (y_ext < CMP_W'(frame_height));
        inv_sa_in     = abp_pkg::CH_MAX - pix_in.src_alpha;
        s1_sa255_next = {pix_in.src_alpha, 8'd0} - abp_pkg::ASUM_W'(pix_in.src_alpha);
        s1_dap_next   = abp_pkg::ASUM_W'(pix_in.dst_alpha) * abp_pkg::ASUM_W'(inv_sa_in);
        for (int c = 0; c < abp_pkg::NUM_CH; c++)
        begin
            s1_sp_next[c] = abp_pkg::PROD_W'(src_vec[c]) *
                            abp_pkg::PROD_W'(pix_in.src_alpha);
            s1_dp_next[c] = abp_pkg::PROD_W'(dst_vec[c]) *
                            abp_pkg::PROD_W'(pix_in.dst_alpha);
        end
        s1_idx_full = EXT_W'(pix_in.pos_y[CRD_W-1:0]) * EXT_W'(frame_width) +
                      EXT_W'(pix_in.pos_x[CRD_W-1:0]);
    end

    always_comb
    begin
        s1_inv_sa    = abp_pkg::CH_MAX - s1_sa_reg;
        s2_asum_next = s1_sa255_reg + s1_dap_reg;
        s2_we_next   = s1_in_frame_reg && (s2_asum_next != '0);
        for (int c = 0; c < abp_pkg::NUM_CH; c++)
        begin
            s2_num_next[c] = (abp_pkg::NUM_W'(s1_sp_reg[c]) << 8) -
                             abp_pkg::NUM_W'(s1_sp_reg[c]) +
                             abp_pkg::NUM_W'(s1_dp_reg[c]) * abp_pkg::NUM_W'(s1_inv_sa);
        end
    end

    always_comb
    begin
        alpha_prod = abp_pkg::RECIP_W'(s2_asum_reg) * abp_pkg::RECIP_W'(abp_pkg::RECIP_255);
        s3_beat_next              = '0;
        s3_beat_next.write_enable = s2_we_reg;
        s3_beat_next.alpha_sum    = abp_pkg::ASUM_BLOCK;
        if (s2_we_reg)
        begin
            s3_beat_next.pixel_index = s2_idx_reg;
            s3_beat_next.alpha       = alpha_prod[abp_pkg::RECIP_SHIFT +: abp_pkg::CH_W];
            s3_beat_next.alpha_sum   = s2_asum_reg;
            s3_beat_next.rem         = s2_num_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= pix_in.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_in_frame_reg <= s1_in_frame_next;
            s1_sa_reg       <= pix_in.src_alpha;
            s1_sa255_reg    <= s1_sa255_next;
            s1_dap_reg      <= s1_dap_next;
            s1_sp_reg       <= s1_sp_next;
            s1_dp_reg       <= s1_dp_next;
            s1_idx_reg      <= s1_idx_full[abp_pkg::IDX_W-1:0];
        end
        if (s2_ready)
        begin
            s2_we_reg   <= s2_we_next;
            s2_asum_reg <= s2_asum_next;
            s2_num_reg  <= s2_num_next;
            s2_idx_reg  <= s1_idx_reg;
        end
        if (s3_ready)
            s3_beat_reg <= s3_beat_next;
    end

    assign out_valid = s3_valid_reg;
    assign out_beat  = s3_beat_reg;

endmodule

[rtl/abp_div_step.sv]
// ----------------------------------------------------------------------------
// abp_div_step
// One restoring division stage: resolves quotient bit STEP of all three
// channels against the shifted combined alpha.
// ----------------------------------------------------------------------------
module abp_div_step #(
    parameter int unsigned STEP = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  abp_pkg::div_beat_t in_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output abp_pkg::div_beat_t out_beat
);

    logic                       valid_reg;
    abp_pkg::div_beat_t         beat_reg;
    abp_pkg::div_beat_t         beat_next;
    logic [abp_pkg::NUM_W-1:0]  divisor;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        divisor   = abp_pkg::NUM_W'(in_beat.alpha_sum) << STEP;
        beat_next = in_beat;
        for (int c = 0; c < abp_pkg::NUM_CH; c++)
        begin
            if (in_beat.rem[c] >= divisor)
            begin
                beat_next.rem[c]       = in_beat.rem[c] - divisor;
                beat_next.quo[c][STEP] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

[tb/sv/abp_blend_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// abp_blend_checker
// Watches the pixel, result and register channels of the alpha-over blend
// unit. Keeps its own copy of the frame size and predicts each blended
// pixel. Compares every result beat, field by field, against the oldest
// prediction. Reports the number of mismatches and the predictions in flight.
// ----------------------------------------------------------------------------
module abp_blend_checker
    import abp_pkg::*;
#(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    abp_pix_in_if       pix_mon,
    abp_pix_out_if      res_mon,
    abp_cfg_if          cfg_mon,
    output int unsigned mismatch_count,
    output int unsigned blend_pending
);

    typedef struct packed {
        logic             write_enable;
        logic [IDX_W-1:0] pixel_index;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  alpha;
    } blend_t;

    blend_t                blend_q[$];
    logic [CFG_DATA_W-1:0] frame_w;
    logic [CFG_DATA_W-1:0] frame_h;

    function automatic logic [CH_W-1:0] over_channel(input int unsigned s, d, sa, da, cov);
        int unsigned q;
        q = (s * sa * 255 + d * da * (255 - sa)) / cov;
        return (q > 255) ? CH_MAX : CH_W'(q);
    endfunction

    function automatic blend_t blend_pixel(
        input logic signed [POS_W-1:0] x,
        input logic signed [POS_W-1:0] y,
        input logic [CH_W-1:0]         sr, sg, sb, sa, dr, dg, db, da,
        input logic [CFG_DATA_W-1:0]   fw, fh
    );
        int          col;
        int          row;
        int unsigned w;
        int unsigned h;
        int unsigned wsa;
        int unsigned wda;
        int unsigned cov;
        blend_t      r;
        r   = '0;
        col = x;
        row = y;
        w   = (fw > MAX_DIM) ? MAX_DIM : int'(fw);
        h   = (fh > MAX_DIM) ? MAX_DIM : int'(fh);
        wsa = sa;
        wda = da;
        cov = wsa * 255 + wda * (255 - wsa);
        if (col < 0 || row < 0 || col >= int'(w) || row >= int'(h) || cov == 0)
            return r;
        r.write_enable = 1'b1;
        r.pixel_index  = IDX_W'(int'(row) * w + col);
        r.red          = over_channel(sr, dr, wsa, wda, cov);
        r.green        = over_channel(sg, dg, wsa, wda, cov);
        r.blue         = over_channel(sb, db, wsa, wda, cov);
        r.alpha        = CH_W'(cov / 255);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        blend_t want;
        if (!rst_n)
        begin
            blend_q.delete();
            frame_w        = CFG_DATA_W'(RESET_DIM);
            frame_h        = CFG_DATA_W'(RESET_DIM);
            mismatch_count = 0;
        end
        else
        begin
            if (res_mon.valid && res_mon.ready)
            begin
                if (blend_q.size() == 0)
                    report_mismatch("result beat with nothing pending", res_mon.pixel_index, 0);
                else
                begin
                    want = blend_q.pop_front();
                    if (res_mon.write_enable !== want.write_enable)
                        report_mismatch("write_enable", res_mon.write_enable, want.write_enable);
                    if (res_mon.pixel_index !== want.pixel_index)
                        report_mismatch("pixel_index", res_mon.pixel_index, want.pixel_index);
                    if (res_mon.out_red !== want.red)
                        report_mismatch("out_red", res_mon.out_red, want.red);
                    if (res_mon.out_green !== want.green)
                        report_mismatch("out_green", res_mon.out_green, want.green);
                    if (res_mon.out_blue !== want.blue)
                        report_mismatch("out_blue", res_mon.out_blue, want.blue);
                    if (res_mon.out_alpha !== want.alpha)
                        report_mismatch("out_alpha", res_mon.out_alpha, want.alpha);
                end
            end
            if (pix_mon.valid && pix_mon.ready)
                blend_q.push_back(blend_pixel(pix_mon.pos_x, pix_mon.pos_y,
                                              pix_mon.src_red, pix_mon.src_green,
                                              pix_mon.src_blue, pix_mon.src_alpha,
                                              pix_mon.dst_red, pix_mon.dst_green,
                                              pix_mon.dst_blue, pix_mon.dst_alpha,
                                              frame_w, frame_h));
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (cfg_mon.index)
                    REG_FRAME_WIDTH:  frame_w = cfg_mon.data;
                    REG_FRAME_HEIGHT: frame_h = cfg_mon.data;
                    default:          ;
                endcase
            end
        end
        blend_pending = blend_q.size();
    end

endmodule

[tb/sv/alpha_over_pixel_blend_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alpha_over_pixel_blend_unit_tb
// Drives pixels and frame-size writes into the alpha-over blend unit. A short
// directed set covers opaque, transparent and zero-coverage blends and the
// frame edges; then random pixels run under a range of frame sizes, from zero
// and one up to oversized, with source gaps and sink stalls in turn. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module alpha_over_pixel_blend_unit_tb;
    import abp_pkg::*;

    localparam int unsigned FRAME_MAX    = 4096;
    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned PHASE_PIXELS = 210;
    localparam int unsigned NUM_PHASES   = 9;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef enum int unsigned {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [CH_W-1:0]         sr, sg, sb, sa, dr, dg, db, da;
    } pixel_req_t;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned gap_pct;
    int unsigned stall_pct;
    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned blend_pending;
    int unsigned eff_w;
    int unsigned eff_h;

    abp_pix_in_if  pix_in_bus();
    abp_pix_out_if pix_out_bus();
    abp_cfg_if     cfg_bus();

    alpha_over_pixel_blend_unit #(.MAX_DIM(FRAME_MAX)) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_bus),
        .pix_out (pix_out_bus),
        .cfg     (cfg_bus)
    );

    abp_blend_checker #(.MAX_DIM(FRAME_MAX)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix_mon        (pix_in_bus),
        .res_mon        (pix_out_bus),
        .cfg_mon        (cfg_bus),
        .mismatch_count (mismatch_count),
        .blend_pending  (blend_pending)
    );

    always #10 clk = ~clk;

    initial
    begin
        pix_out_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            pix_out_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic pixel_req_t pixel_of(input int x, y,
                                            input int unsigned sr, sg, sb, sa,
                                            input int unsigned dr, dg, db, da);
        pixel_req_t p;
        p.x  = POS_W'(x);
        p.y  = POS_W'(y);
        p.sr = CH_W'(sr);
        p.sg = CH_W'(sg);
        p.sb = CH_W'(sb);
        p.sa = CH_W'(sa);
        p.dr = CH_W'(dr);
        p.dg = CH_W'(dg);
        p.db = CH_W'(db);
        p.da = CH_W'(da);
        return p;
    endfunction

    function automatic int unsigned pick_level();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    function automatic int pick_coord(input int unsigned dim);
        if (dim > 0 && $urandom_range(99) < 85)
            return $urandom_range(dim - 1);
        case ($urandom_range(2))
            0:       return $urandom;
            1:       return dim + $urandom_range(3);
            default: return -1 - int'($urandom_range(3));
        endcase
    endfunction

    function automatic pixel_req_t random_pixel(input int unsigned w, h);
        return pixel_of(pick_coord(w), pick_coord(h),
                        pick_level(), pick_level(), pick_level(), pick_level(),
                        pick_level(), pick_level(), pick_level(), pick_level());
    endfunction

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SRC:  begin gap_pct = 52; stall_pct = 0;  end
            IDLE_SINK: begin gap_pct = 0;  stall_pct = 52; end
            IDLE_BOTH: begin gap_pct = 24; stall_pct = 24; end
            default:   begin gap_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // call at a falling edge; returns at a falling edge with valid left high
    task automatic push_pixel(input pixel_req_t p);
        while ($urandom_range(99) < gap_pct)
        begin
            pix_in_bus.valid <= 1'b0;
            @(negedge clk);
        end
        pix_in_bus.pos_x     <= p.x;
        pix_in_bus.pos_y     <= p.y;
        pix_in_bus.src_red   <= p.sr;
        pix_in_bus.src_green <= p.sg;
        pix_in_bus.src_blue  <= p.sb;
        pix_in_bus.src_alpha <= p.sa;
        pix_in_bus.dst_red   <= p.dr;
        pix_in_bus.dst_green <= p.dg;
        pix_in_bus.dst_blue  <= p.db;
        pix_in_bus.dst_alpha <= p.da;
        pix_in_bus.valid     <= 1'b1;
        @(posedge clk);
        while (!pix_in_bus.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_bus.index <= idx;
        cfg_bus.data  <= CFG_DATA_W'(value);
        cfg_bus.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    // drop valid, then hold until every blend has come back
    task automatic drain();
        pix_in_bus.valid <= 1'b0;
        while (blend_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int unsigned phase_w[NUM_PHASES];
        int unsigned phase_h[NUM_PHASES];

        phase_w = '{1, 4096, 8191, 0, 640, 4097, 13, 1920, 1024};
        phase_h = '{1, 4096, 8191, 37, 0, 3, 4096, 1080, 1024};

        rst_n                = 1'b0;
        pix_in_bus.valid     = 1'b0;
        pix_in_bus.pos_x     = '0;
        pix_in_bus.pos_y     = '0;
        pix_in_bus.src_red   = '0;
        pix_in_bus.src_green = '0;
        pix_in_bus.src_blue  = '0;
        pix_in_bus.src_alpha = '0;
        pix_in_bus.dst_red   = '0;
        pix_in_bus.dst_green = '0;
        pix_in_bus.dst_blue  = '0;
        pix_in_bus.dst_alpha = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = REG_FRAME_WIDTH;
        cfg_bus.data         = '0;
        set_idle(IDLE_NONE);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_pixel(pixel_of(0, 0, 255, 255, 255, 255, 0, 0, 0, 0));
        push_pixel(pixel_of(1023, 1023, 10, 20, 30, 0, 200, 100, 50, 255));
        push_pixel(pixel_of(512, 300, 255, 0, 128, 128, 0, 255, 64, 200));
        push_pixel(pixel_of(1, 2, 255, 255, 255, 0, 255, 255, 255, 0));
        push_pixel(pixel_of(5, 5, 255, 255, 255, 1, 255, 255, 255, 0));
        push_pixel(pixel_of(6, 6, 0, 0, 0, 0, 255, 255, 255, 1));
        push_pixel(pixel_of(7, 7, 255, 255, 255, 255, 255, 255, 255, 255));
        push_pixel(pixel_of(8, 9, 0, 0, 0, 255, 255, 255, 255, 255));
        push_pixel(pixel_of(100, 200, 0, 255, 0, 254, 255, 0, 255, 255));
        push_pixel(pixel_of(1023, 0, 17, 34, 51, 1, 200, 150, 100, 254));
        push_pixel(pixel_of(0, 1023, 99, 88, 77, 127, 11, 22, 33, 1));
        push_pixel(pixel_of(1024, 0, 255, 255, 255, 255, 0, 0, 0, 255));
        push_pixel(pixel_of(0, 1024, 255, 255, 255, 255, 0, 0, 0, 255));
        push_pixel(pixel_of(-1, 0, 255, 255, 255, 255, 0, 0, 0, 255));
        push_pixel(pixel_of(0, -1, 255, 255, 255, 255, 0, 0, 0, 255));
        push_pixel(pixel_of(-8192, -8192, 255, 255, 255, 255, 255, 255, 255, 255));
        push_pixel(pixel_of(8191, 8191, 255, 255, 255, 255, 255, 255, 255, 255));
        push_pixel(pixel_of(-8192, 8191, 1, 2, 3, 4, 5, 6, 7, 8));
        push_pixel(pixel_of(8191, 0, 1, 2, 3, 4, 5, 6, 7, 8));
        drain();

        for (int unsigned ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_reg(REG_FRAME_WIDTH, phase_w[ph]);
            write_reg(REG_FRAME_HEIGHT, phase_h[ph]);
            eff_w = (phase_w[ph] > FRAME_MAX) ? FRAME_MAX : phase_w[ph];
            eff_h = (phase_h[ph] > FRAME_MAX) ? FRAME_MAX : phase_h[ph];
            set_idle(idle_mode_t'(ph % 4));
            repeat (PHASE_PIXELS) push_pixel(random_pixel(eff_w, eff_h));
            drain();
        end

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/abp_pkg.sv
rtl/abp_ifs.sv
rtl/abp_front.sv
rtl/abp_div_step.sv
rtl/alpha_over_pixel_blend_unit.sv
tb/sv/abp_blend_checker.sv
tb/sv/alpha_over_pixel_blend_unit_tb.sv
